// ----- rtl/core/fmws_pkg.sv -----
// Shared types, fixed-point constants and helpers for the FM operator waveform shaper.
package fmws_pkg;

    // Q1.30 amplitude: 1.0 = 2^30, held as a 31-bit magnitude
    localparam int unsigned Q_W = 31;
    typedef logic [Q_W-1:0] t_q;

    localparam t_q ONE_Q30 = 31'h4000_0000;
    // Quintic quarter-sine coefficients in Q30
    localparam t_q COEF_A  = 31'd1686629713;
    localparam t_q COEF_B  = 31'd688904866;
    localparam t_q COEF_C  = 31'd76016977;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Waveform selector codes
    localparam logic [3:0] SHAPE_SINE       = 4'd0;
    localparam logic [3:0] SHAPE_HALF       = 4'd1;
    localparam logic [3:0] SHAPE_ABS        = 4'd2;
    localparam logic [3:0] SHAPE_QUARTER    = 4'd3;
    localparam logic [3:0] SHAPE_DOUBLE     = 4'd4;
    localparam logic [3:0] SHAPE_DOUBLE_ABS = 4'd5;
    localparam logic [3:0] SHAPE_SQUARE     = 4'd6;
    localparam logic [3:0] SHAPE_HALF_COS   = 4'd7;
    localparam logic [3:0] SHAPE_ROUND_SQ   = 4'd8;
    localparam logic [3:0] SHAPE_LOG_SAW    = 4'd9;
    localparam logic [3:0] SHAPE_PLAIN      = 4'd10;

    // Control that travels with each sample down the pipeline
    typedef struct packed {
        logic [3:0] sel;
        logic       first_half;
        logic       first_quarter;
        logic       neg;
    } t_ctl;

    // Q30 product, truncated; both operands are non-negative and below 2^31
    function automatic t_q mul_q30(input t_q a, input t_q b);
        logic [2*Q_W-1:0] p;
        p = a * b;
        return p[Q_W+29:30];
    endfunction

endpackage

// ----- rtl/core/fmws_phase_map.sv -----
// Input stage: maps phase and selector to a quarter-wave argument and control.
module fmws_phase_map #(
    parameter int PHASE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [PHASE_BITS-1:0] i_phase,
    input  logic [3:0]            i_shape,
    output logic                  o_valid,
    output fmws_pkg::t_q          o_x,
    output fmws_pkg::t_ctl        o_ctl
);
    import fmws_pkg::*;

    logic [31:0] turn;
    logic [31:0] arg;
    logic [3:0]  sel;
    t_q          half_turn;
    t_q          x_raw;
    t_q          x_sine;
    t_q          x_saw;
    logic        saw_neg;
    t_q          n_x;
    t_ctl        n_ctl;
    logic        r_valid;
    t_q          r_x;
    t_ctl        r_ctl;

    always_comb begin
        turn = {i_phase, {(32-PHASE_BITS){1'b0}}};
        sel  = (i_shape > SHAPE_PLAIN) ? SHAPE_PLAIN : i_shape;

        case (sel) inside
            SHAPE_DOUBLE, SHAPE_DOUBLE_ABS: arg = {turn[30:0], 1'b0};
            SHAPE_HALF_COS:                 arg = {1'b0, turn[31:1]} + QUARTER_TURN;
            default:                        arg = turn;
        endcase

        // fold into the first quadrant
        x_raw  = {1'b0, arg[29:0]};
        x_sine = arg[30] ? (ONE_Q30 - x_raw) : x_raw;

        // log saw base: 1 - 2x as sign and magnitude
        half_turn = turn[31:1];
        saw_neg   = half_turn > ONE_Q30;
        x_saw     = saw_neg ? (half_turn - ONE_Q30) : (ONE_Q30 - half_turn);

        n_x               = (sel == SHAPE_LOG_SAW) ? x_saw : x_sine;
        n_ctl.sel         = sel;
        n_ctl.first_half  = ~turn[31];
        n_ctl.first_quarter = (turn[31:30] == 2'b00);
        n_ctl.neg         = (sel == SHAPE_LOG_SAW) ? saw_neg : arg[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_ctl <= n_ctl;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_ctl   = r_ctl;

endmodule

// ----- rtl/core/fmws_sine_core.sv -----
// Quintic quarter-sine evaluator, one multiply per stage; also forms the saw cube.
module fmws_sine_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fmws_pkg::t_q   i_x,
    input  fmws_pkg::t_ctl i_ctl,
    output logic           o_valid,
    output fmws_pkg::t_q   o_m,
    output fmws_pkg::t_ctl o_ctl
);
    import fmws_pkg::*;

    logic [3:0] r_valid;
    t_q         r2_x, r2_x2;
    t_ctl       r2_ctl;
    t_q         r3_x, r3_x2, r3_t1;
    t_ctl       r3_ctl;
    t_q         r4_x, r4_x2, r4_t2;
    t_ctl       r4_ctl;
    t_q         r5_m;
    t_ctl       r5_ctl;
    t_q         n_t1, n_t2, n_m;

    always_comb begin
        n_t1 = COEF_B - mul_q30(r2_x2, COEF_C);
        n_t2 = COEF_A - mul_q30(r3_x2, r3_t1);
        // saw reuses the last multiplier for x * x^2
        n_m  = mul_q30(r4_x, (r4_ctl.sel == SHAPE_LOG_SAW) ? r4_x2 : r4_t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r2_x   <= i_x;
        r2_x2  <= mul_q30(i_x, i_x);
        r2_ctl <= i_ctl;
        r3_x   <= r2_x;
        r3_x2  <= r2_x2;
        r3_t1  <= n_t1;
        r3_ctl <= r2_ctl;
        r4_x   <= r3_x;
        r4_x2  <= r3_x2;
        r4_t2  <= n_t2;
        r4_ctl <= r3_ctl;
        r5_m   <= n_m;
        r5_ctl <= r4_ctl;
    end

    assign o_valid = r_valid[3];
    assign o_m     = r5_m;
    assign o_ctl   = r5_ctl;

endmodule

// ----- rtl/core/fmws_shape_mix.sv -----
// Shape stages: rounded-square fourth power and per-waveform sign/magnitude select.
module fmws_shape_mix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fmws_pkg::t_q   i_m,
    input  fmws_pkg::t_ctl i_ctl,
    output logic           o_valid,
    output fmws_pkg::t_q   o_mag,
    output logic           o_neg
);
    import fmws_pkg::*;

    logic [2:0] r_valid;
    t_q         r6_m, r6_d2;
    t_ctl       r6_ctl;
    t_q         r7_m, r7_d4;
    t_ctl       r7_ctl;
    t_q         r8_mag;
    logic       r8_neg;
    t_q         n_d;
    t_q         n_mag;
    logic       n_neg;

    assign n_d = ONE_Q30 - i_m;

    always_comb begin
        n_mag = r7_m;
        n_neg = r7_ctl.neg;
        case (r7_ctl.sel) inside
            SHAPE_HALF, SHAPE_DOUBLE: begin
                n_mag = r7_ctl.first_half ? r7_m : '0;
            end
            SHAPE_ABS: begin
                n_neg = 1'b0;
            end
            SHAPE_QUARTER: begin
                n_mag = r7_ctl.first_quarter ? r7_m : '0;
            end
            SHAPE_DOUBLE_ABS: begin
                n_mag = r7_ctl.first_half ? r7_m : '0;
                n_neg = 1'b0;
            end
            SHAPE_SQUARE: begin
                n_mag = ONE_Q30;
                n_neg = ~r7_ctl.first_half;
            end
            SHAPE_ROUND_SQ: begin
                n_mag = ONE_Q30 - r7_d4;
                n_neg = ~r7_ctl.first_half;
            end
            default: begin
                n_mag = r7_m;
                n_neg = r7_ctl.neg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r6_m   <= i_m;
        r6_d2  <= mul_q30(n_d, n_d);
        r6_ctl <= i_ctl;
        r7_m   <= r6_m;
        r7_d4  <= mul_q30(r6_d2, r6_d2);
        r7_ctl <= r6_ctl;
        r8_mag <= n_mag;
        r8_neg <= n_neg;
    end

    assign o_valid = r_valid[2];
    assign o_mag   = r8_mag;
    assign o_neg   = r8_neg;

endmodule

// ----- rtl/core/fmws_out_round.sv -----
// Output stage: round half away from zero, saturate and apply sign.
module fmws_out_round #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  fmws_pkg::t_q                  i_mag,
    input  logic                          i_neg,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    import fmws_pkg::*;

    localparam int          SH   = 31 - SAMPLE_BITS;
    localparam logic [31:0] RND  = 32'd1 << (SH - 1);
    localparam logic [SAMPLE_BITS:0] FULL = {2'b00, {(SAMPLE_BITS-1){1'b1}}};

    logic [31:0]            sum;
    logic [SAMPLE_BITS:0]   rmag;
    logic [SAMPLE_BITS-1:0] sat;
    logic [SAMPLE_BITS-1:0] n_sample;
    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] r_sample;

    always_comb begin
        sum      = {1'b0, i_mag} + RND;
        rmag     = sum[31:SH];
        sat      = (rmag > FULL) ? FULL[SAMPLE_BITS-1:0] : rmag[SAMPLE_BITS-1:0];
        n_sample = i_neg ? (~sat + 1'b1) : sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

// ----- rtl/core/fm_operator_waveform_shaper_top.sv -----
// FM operator waveform shaper: phase in, one saturated Q1.15-style sample out per transaction.
// Each result is registered through the phase-map, sine-core, shape-mix and output stages to o_valid.
// Throughput: one transaction per cycle; o_busy stays low, the multiplier stages are fully
//   pipelined (six chained 31x31 multiply stages set the depth) and the receiver cannot stall.
// Reset (i_rst_n low, synchronous): clears all stage valid bits and sets wave_shape to sine;
//   transactions in flight are dropped.
module fm_operator_waveform_shaper_top #(
    parameter int PHASE_BITS  = 12,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [PHASE_BITS-1:0]         i_phase,
    // configuration: wave_shape register
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_wave_shape,
    // result strobe
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    import fmws_pkg::*;

    localparam int LATENCY = 9;

    logic [3:0] r_wave_shape;
    logic       accept;

    logic       map_valid;
    t_q         map_x;
    t_ctl       map_ctl;
    logic       core_valid;
    t_q         core_m;
    t_ctl       core_ctl;
    logic       mix_valid;
    t_q         mix_mag;
    logic       mix_neg;

    // The pipeline never holds off a command.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Selector register; the user must write it only while no transaction is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape <= SHAPE_SINE;
        end else if (i_cfg_we) begin
            r_wave_shape <= i_wave_shape;
        end
    end

    // Stage 1: fold phase into a quarter-wave argument, clamp the selector.
    fmws_phase_map #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_phase (i_phase),
        .i_shape (r_wave_shape),
        .o_valid (map_valid),
        .o_x     (map_x),
        .o_ctl   (map_ctl)
    );

    // Stages 2-5: quintic sine magnitude, or the saw cube.
    fmws_sine_core u_sine_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (map_valid),
        .i_x     (map_x),
        .i_ctl   (map_ctl),
        .o_valid (core_valid),
        .o_m     (core_m),
        .o_ctl   (core_ctl)
    );

    // Stages 6-8: fourth power for the rounded square, then per-shape select.
    fmws_shape_mix u_shape_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .i_m     (core_m),
        .i_ctl   (core_ctl),
        .o_valid (mix_valid),
        .o_mag   (mix_mag),
        .o_neg   (mix_neg)
    );

    // Stage 9: round, saturate, sign; registered result strobe.
    fmws_out_round #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mix_valid),
        .i_mag    (mix_mag),
        .i_neg    (mix_neg),
        .o_valid  (o_valid),
        .o_sample (o_sample)
    );

`ifndef SYNTHESIS
    // Every accepted transaction is followed by a result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("accepted transaction produced no result");

    // No result without a matching accepted transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result strobe without a transaction");

    // Saturation keeps the most negative code out of the result.
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("sample not saturated");
`endif

endmodule

// ----- bench/fm_operator_waveform_shaper_top_test.sv -----
// Self-checking testbench for the FM operator waveform shaper: every shape, random phases.
`timescale 1ns / 100ps

module fm_operator_waveform_shaper_top_test;
    import fmws_pkg::*;

    // Q30 fixed point used by the sample predictor: 1.0 = 2^30
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam longint HALF_Q30 = UNIT_Q30 / 2;
    // Odd quintic for the quarter-wave sine: x*(A - x^2*(B - x^2*C))
    localparam longint POLY_A = 64'sd1686629713;
    localparam longint POLY_B = 2 * POLY_A - 5 * HALF_Q30;
    localparam longint POLY_C = POLY_A - 3 * HALF_Q30;
    // Largest sample code; the most negative code is never produced
    localparam longint FULL_CODE = 32767;
    // Pipeline depth from the top level, plus margin, for the final settle
    localparam int SETTLE_CYCLES = 12;
    // Hard stop: far beyond the slowest correct run
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int ITEMS_PER_SHAPE = 70;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                o_busy;
    logic [11:0]         i_phase = '0;
    logic                i_cfg_we = 1'b0;
    logic [3:0]          i_wave_shape = '0;
    logic                o_valid;
    logic signed [15:0]  o_sample;

    // Predictor copy of the wave_shape register, and the samples still owed by the block
    logic [3:0]          shape_reg = SHAPE_SINE;
    logic signed [15:0]  samples_due[$];
    logic signed [15:0]  oldest_due;
    int                  mismatches = 0;

    fm_operator_waveform_shaper_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_phase      (i_phase),
        .i_cfg_we     (i_cfg_we),
        .i_wave_shape (i_wave_shape),
        .o_valid      (o_valid),
        .o_sample     (o_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sample predictor
    // ------------------------------------------------------------------

    // Truncating Q30 product; operands are non-negative and at most 2^31
    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // sin(pi/2 * x) for x in [0, 1], Q30 in and out
    function automatic longint quarter_arc(input longint x);
        longint x2;
        longint acc;
        x2  = q30_mul(x, x);
        acc = POLY_B - q30_mul(x2, POLY_C);
        acc = POLY_A - q30_mul(x2, acc);
        return q30_mul(x, acc);
    endfunction

    // Sine of a 32-bit turn fraction; fold into the first quadrant, restore the sign
    function automatic longint turn_sine(input logic [31:0] turn);
        longint x;
        longint m;
        x = {34'd0, turn[29:0]};
        if (turn[30])
            x = UNIT_Q30 - x;
        m = quarter_arc(x);
        return turn[31] ? -m : m;
    endfunction

    // Expected output code for one phase under the given selector
    function automatic logic signed [15:0] shaped_sample(input logic [3:0] shape,
                                                         input logic [11:0] phase);
        logic [31:0]        turn;
        logic [31:0]        warped;
        logic [3:0]         sel;
        logic               first_half;
        longint             s;
        longint             d;
        longint             m;
        longint             v;
        longint             mag;
        logic signed [15:0] code;
        turn       = {phase, 20'd0};
        // Selector codes above plain sine behave as plain sine
        sel        = (shape > SHAPE_PLAIN) ? SHAPE_PLAIN : shape;
        first_half = ~turn[31];
        s          = turn_sine(turn);
        case (sel)
            SHAPE_HALF:       v = first_half ? s : 0;
            SHAPE_ABS:        v = magnitude(s);
            SHAPE_QUARTER:    v = (turn[31:30] == 2'b00) ? s : 0;
            SHAPE_DOUBLE: begin
                warped = turn << 1;
                v = first_half ? turn_sine(warped) : 0;
            end
            SHAPE_DOUBLE_ABS: begin
                warped = turn << 1;
                v = first_half ? magnitude(turn_sine(warped)) : 0;
            end
            SHAPE_SQUARE:     v = first_half ? UNIT_Q30 : -UNIT_Q30;
            SHAPE_HALF_COS: begin
                warped = (turn >> 1) + QUARTER_TURN;
                v = turn_sine(warped);
            end
            SHAPE_ROUND_SQ: begin
                d = UNIT_Q30 - magnitude(s);
                d = q30_mul(d, d);
                d = q30_mul(d, d);
                m = UNIT_Q30 - d;
                v = first_half ? m : -m;
            end
            SHAPE_LOG_SAW: begin
                d = UNIT_Q30 - longint'({33'd0, turn[31:1]});
                m = magnitude(d);
                m = q30_mul(q30_mul(m, m), m);
                v = (d < 0) ? -m : m;
            end
            default:          v = s;
        endcase
        // Round half away from zero to 15 fraction bits, then saturate
        mag = (magnitude(v) + (64'sd1 << 14)) >>> 15;
        if (mag > FULL_CODE)
            mag = FULL_CODE;
        code = mag[15:0];
        return (v < 0) ? -code : code;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Quadrant boundaries and the ends of the phase range
    function automatic logic [11:0] corner_phase(input int idx);
        case (idx)
            0:       return 12'd0;
            1:       return 12'd1023;
            2:       return 12'd1024;
            3:       return 12'd1025;
            4:       return 12'd2047;
            5:       return 12'd2048;
            6:       return 12'd3071;
            7:       return 12'd3072;
            default: return 12'd4095;
        endcase
    endfunction

    function automatic logic [11:0] pick_phase();
        if ($urandom_range(0, 7) == 0)
            return corner_phase($urandom_range(0, 8));
        return 12'($urandom_range(0, 4095));
    endfunction

    // Send one phase transaction. Call at a rising edge; returns at a rising edge.
    // Hold start high across back-to-back transactions, drop it only for a gap.
    task automatic issue_phase(input logic [11:0] phase, input bit no_gaps);
        int gap;
        i_start <= 1'b1;
        i_phase <= phase;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        samples_due.push_back(shaped_sample(shape_reg, phase));
        gap = no_gaps ? 0 : draw_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            // Scramble the idle phase bus; the block must ignore it
            i_phase <= 12'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop issuing and hold until every owed sample has come back
    task automatic drain_results();
        i_start <= 1'b0;
        wait (samples_due.size() == 0);
        @(posedge i_clk);
    endtask

    // Write the wave_shape register while the pipeline is empty
    task automatic load_shape(input logic [3:0] shape);
        drain_results();
        i_cfg_we     <= 1'b1;
        i_wave_shape <= shape;
        @(posedge i_clk);
        shape_reg    = shape;
        i_cfg_we     <= 1'b0;
        i_wave_shape <= 4'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves the selector at sine: full-scale peaks and zero crossings, back-to-back
    task automatic check_reset_shape();
        issue_phase(12'd0, 1'b1);
        issue_phase(12'd1, 1'b1);
        issue_phase(12'd1023, 1'b1);
        issue_phase(12'd1024, 1'b1);
        issue_phase(12'd2048, 1'b1);
        issue_phase(12'd3072, 1'b1);
        issue_phase(12'd4095, 1'b0);
    endtask

    // One write per selector code from 1 to 15, the out-of-range codes too, each with two corner phases
    task automatic sweep_every_shape();
        for (int s = 1; s < 16; s++) begin
            load_shape(4'(s));
            issue_phase(corner_phase(s % 9), 1'b0);
            issue_phase(corner_phase((s + 4) % 9), 1'b1);
        end
    endtask

    // Random phases under every selector; four passes run without gaps,
    // and one pauses midway until the pipeline has emptied
    task automatic random_shape_phases();
        logic [3:0] shape;
        bit         no_gaps;
        for (int k = 0; k < 16; k++) begin
            // Stride 7 visits all sixteen codes, starting from 0 and reaching 15 on the tenth pass
            shape   = 4'((k * 7) % 16);
            no_gaps = (k % 4 == 1);
            load_shape(shape);
            for (int n = 0; n < ITEMS_PER_SHAPE; n++) begin
                if (k == 3 && n == ITEMS_PER_SHAPE / 2)
                    drain_results();
                issue_phase(pick_phase(), no_gaps);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: the receiver cannot stall, so take every strobe
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (samples_due.size() == 0) begin
                $error("sample: expected none, got %0d", o_sample);
                mismatches++;
            end else begin
                oldest_due = samples_due.pop_front();
                if (o_sample !== oldest_due) begin
                    $error("sample: expected %0d, got %0d", oldest_due, o_sample);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_reset_shape();
        sweep_every_shape();
        random_shape_phases();

        // Let the last transactions leave the pipeline, then settle
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/fmws_pkg.sv
rtl/core/fmws_phase_map.sv
rtl/core/fmws_sine_core.sv
rtl/core/fmws_shape_mix.sv
rtl/core/fmws_out_round.sv
rtl/core/fm_operator_waveform_shaper_top.sv
bench/fm_operator_waveform_shaper_top_test.sv
